/* design/hvd_pkg.sv */
// ----------------------------------------------------------------------------
// hvd_pkg
// Shared constants, types, the arctangent table and the Q30 multiply for the haversine block.
// ----------------------------------------------------------------------------
package hvd_pkg;

  localparam int AngleFracBits = 20;
  localparam int CordicStages  = 24;

  // CORDIC datapath width, square-root step parameter, root, radius and distance widths
  localparam int CW         = 34;
  localparam int SqrtSteps  = 30;
  localparam int SqrtW      = 32;
  localparam int RadW       = 24;
  localparam int DistW      = 26;

  localparam logic signed [CW-1:0] Q30One    = 34'sd1073741824;
  localparam logic signed [35:0]   Q30Pi     = 36'sd3373259426;
  localparam logic signed [35:0]   Q30TwoPi  = 36'sd6746518852;
  localparam logic signed [35:0]   Q30HalfPi = 36'sd1686629713;
  localparam logic signed [31:0]   DegToRad  = 32'sd1199381129;
  localparam logic signed [CW-1:0] InvGain   = 34'sd652032874;
  localparam logic [RadW-1:0]      RadiusReset = 24'd6371000;

  typedef logic signed [CW-1:0] q30_t;

  // atan(2^-i) in Q30, truncated
  function automatic q30_t atan_tab(input int i);
    q30_t v;
    v = '0;
    unique case (i)
      0:  v = 34'sd843314856;  1:  v = 34'sd497837829;
      2:  v = 34'sd263043836;  3:  v = 34'sd133525158;
      4:  v = 34'sd67021686;   5:  v = 34'sd33543515;
      6:  v = 34'sd16775850;   7:  v = 34'sd8388437;
      8:  v = 34'sd4194282;    9:  v = 34'sd2097149;
      10: v = 34'sd1048575;    11: v = 34'sd524287;
      12: v = 34'sd262143;     13: v = 34'sd131071;
      14: v = 34'sd65535;      15: v = 34'sd32767;
      16: v = 34'sd16383;      17: v = 34'sd8191;
      18: v = 34'sd4095;       19: v = 34'sd2047;
      20: v = 34'sd1023;       21: v = 34'sd511;
      22: v = 34'sd255;        23: v = 34'sd127;
      24: v = 34'sd63;         25: v = 34'sd31;
      26: v = 34'sd15;         27: v = 34'sd7;
      28: v = 34'sd3;          29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q30 product rounded half up
  function automatic q30_t mul_q30(input q30_t a, input q30_t b);
    logic signed [2*CW-1:0] p;
    p = (a * b) + (68'sd1 <<< 29);
    return q30_t'(p >>> 30);
  endfunction

endpackage

/* design/hvd_sincos.sv */
// ----------------------------------------------------------------------------
// hvd_sincos
// Pipelined rotation-mode CORDIC: reduce an angle to [-pi/2,pi/2], then one
// micro-rotation per stage. Advances when en is high.
// ----------------------------------------------------------------------------
module hvd_sincos (
  input  logic                clk,
  input  logic                en,
  input  logic signed [35:0]  angle,
  output hvd_pkg::q30_t       sin_o,
  output hvd_pkg::q30_t       cos_o
);

  localparam int N = hvd_pkg::CordicStages;

  logic signed [35:0] red_r;
  logic               neg0_r;
  hvd_pkg::q30_t      x_r [N+1];
  hvd_pkg::q30_t      y_r [N+1];
  hvd_pkg::q30_t      z_r [N+1];
  logic               neg_r [N+1];
  logic signed [35:0] t_nxt;
  logic signed [35:0] t_red;
  logic               neg_nxt;

  // reduce modulo 2*pi into [-pi,pi) (input magnitude stays below 2.5*pi)
  always_comb begin
    t_nxt = angle;
    if (t_nxt >= hvd_pkg::Q30Pi) begin
      t_nxt = t_nxt - hvd_pkg::Q30TwoPi;
    end else if (t_nxt < -hvd_pkg::Q30Pi) begin
      t_nxt = t_nxt + hvd_pkg::Q30TwoPi;
    end
  end

  // fold into [-pi/2,pi/2]
  always_comb begin
    t_red   = red_r;
    neg_nxt = 1'b0;
    if (red_r > hvd_pkg::Q30HalfPi) begin
      t_red   = red_r - hvd_pkg::Q30Pi;
      neg_nxt = 1'b1;
    end else if (red_r < -hvd_pkg::Q30HalfPi) begin
      t_red   = red_r + hvd_pkg::Q30Pi;
      neg_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r  <= t_nxt;
      x_r[0] <= hvd_pkg::InvGain;
      y_r[0] <= '0;
      z_r[0] <= hvd_pkg::q30_t'(t_red);
      neg_r[0] <= neg_nxt;
    end
  end

  // micro-rotation stages
  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][hvd_pkg::CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - hvd_pkg::atan_tab(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + hvd_pkg::atan_tab(i);
        end
        neg_r[i+1] <= neg_r[i];
      end
    end
  end

  assign sin_o = neg_r[N] ? -y_r[N] : y_r[N];
  assign cos_o = neg_r[N] ? -x_r[N] : x_r[N];

  logic unused_z;
  assign unused_z = ^z_r[N] ^ neg0_r;
  always_ff @(posedge clk) neg0_r <= 1'b0;

endmodule

/* design/hvd_isqrt.sv */
// ----------------------------------------------------------------------------
// hvd_isqrt
// Pipelined floor square root of v << 30 for v in [0, 2^30], one result bit
// per stage.
// ----------------------------------------------------------------------------
module hvd_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [30:0]                   val,
  output logic [hvd_pkg::SqrtW-1:0]     root
);

  localparam int S = hvd_pkg::SqrtSteps + 1;

  logic [61:0] rem_r [S+1];
  logic [31:0] res_r [S+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {val, 31'd0} >> 1;
      res_r[0] <= '0;
    end
  end

  // restoring digit-by-digit root, one bit per stage
  for (genvar k = 0; k < S; k++) begin : g_bit
    localparam int B = S - 1 - k;
    logic [63:0] trial;
    assign trial = ({32'd0, res_r[k]} << (B + 1)) + (64'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'b00, rem_r[k]} >= trial) begin
          rem_r[k+1] <= rem_r[k] - trial[61:0];
          res_r[k+1] <= res_r[k] | (32'd1 << B);
        end else begin
          rem_r[k+1] <= rem_r[k];
          res_r[k+1] <= res_r[k];
        end
      end
    end
  end

  assign root = res_r[S];

endmodule

/* design/haversine_distance.sv */
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance of two points on a sphere of configurable radius.
// ----------------------------------------------------------------------------
// Latitude/longitude pairs enter one word per cycle while the output is not
// stalled; an accepted input word passes the 26-register rotation CORDICs, the
// 32-register root and the 25-register vectoring CORDIC on its way to the output.
// The pipeline advances whenever the output register is free or being taken.
// Synchronous active-low reset clears valid bits and loads the default radius.
module haversine_distance (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // lat_a[27:0], lon_a[56:28], lat_b[84:57], lon_b[113:85], zero pad
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // distance[25:0], zero pad
  output logic [31:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [23:0]  cfg_data
);

  localparam int NR  = hvd_pkg::CordicStages + 2;
  localparam int NC  = hvd_pkg::CordicStages + 1;
  localparam int NQ  = hvd_pkg::SqrtSteps + 2;
  localparam int LAT = 2 + NR + 3 + NQ + NC + 2;
  localparam int HalfSh = hvd_pkg::AngleFracBits + 7;
  localparam int LatSh  = hvd_pkg::AngleFracBits + 6;

  logic en;
  logic [LAT-1:0] vld_r;
  logic [23:0] radius_r;
  logic [25:0] dist_r;
  logic        ovld_r;

  assign en        = !ovld_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= hvd_pkg::RadiusReset;
    end else if (cfg_valid) begin
      radius_r <= cfg_data;
    end
  end

  // stage 0: differences
  logic signed [27:0] la, lb;
  logic signed [28:0] oa, ob;
  assign la = in_tdata[27:0];
  assign oa = in_tdata[56:28];
  assign lb = in_tdata[84:57];
  assign ob = in_tdata[113:85];

  logic signed [29:0] dlat_r, dlon_r;
  logic signed [27:0] la_r, lb_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dlat_r <= 30'(la) - 30'(lb);
      dlon_r <= 30'(oa) - 30'(ob);
      la_r   <= la;
      lb_r   <= lb;
    end
  end

  // stage 1: degrees to radians (half angles for the differences), rounded half up
  logic signed [35:0] hdlat_r, hdlon_r, rada_r, radb_r;
  logic signed [63:0] p_dlat, p_dlon, p_la, p_lb;
  assign p_dlat = 64'(dlat_r) * 64'(hvd_pkg::DegToRad);
  assign p_dlon = 64'(dlon_r) * 64'(hvd_pkg::DegToRad);
  assign p_la   = 64'(la_r) * 64'(hvd_pkg::DegToRad);
  assign p_lb   = 64'(lb_r) * 64'(hvd_pkg::DegToRad);
  always_ff @(posedge clk) begin
    if (en) begin
      hdlat_r <= 36'((p_dlat + (64'sd1 <<< (HalfSh - 1))) >>> HalfSh);
      hdlon_r <= 36'((p_dlon + (64'sd1 <<< (HalfSh - 1))) >>> HalfSh);
      rada_r  <= 36'((p_la + (64'sd1 <<< (LatSh - 1))) >>> LatSh);
      radb_r  <= 36'((p_lb + (64'sd1 <<< (LatSh - 1))) >>> LatSh);
    end
  end

  hvd_pkg::q30_t s1, c1, s2, c2, sa, ca, sb, cb;
  hvd_sincos u_sc1 (.clk, .en, .angle(hdlat_r), .sin_o(s1), .cos_o(c1));
  hvd_sincos u_sc2 (.clk, .en, .angle(hdlon_r), .sin_o(s2), .cos_o(c2));
  hvd_sincos u_sca (.clk, .en, .angle(rada_r),  .sin_o(sa), .cos_o(ca));
  hvd_sincos u_scb (.clk, .en, .angle(radb_r),  .sin_o(sb), .cos_o(cb));

  // products of h, one multiplier level per stage
  hvd_pkg::q30_t m11_r, m22_r, mcc_r, t1_r, t2_r;
  logic [30:0] h_r, hc_r;
  logic signed [hvd_pkg::CW:0] hsum;
  always_ff @(posedge clk) begin
    if (en) begin
      m11_r <= hvd_pkg::mul_q30(s1, s1);
      m22_r <= hvd_pkg::mul_q30(s2, s2);
      mcc_r <= hvd_pkg::mul_q30(ca, cb);
      t1_r  <= m11_r;
      t2_r  <= hvd_pkg::mul_q30(mcc_r, m22_r);
    end
  end
  assign hsum = 35'(t1_r) + 35'(t2_r);
  always_ff @(posedge clk) begin
    if (en) begin
      if (hsum < 0) begin
        h_r <= '0;
      end else if (hsum > 35'(hvd_pkg::Q30One)) begin
        h_r <= 31'd1073741824;
      end else begin
        h_r <= hsum[30:0];
      end
    end
  end
  assign hc_r = 31'd1073741824 - h_r;

  logic [31:0] rt_h, rt_c;
  hvd_isqrt u_sqh (.clk, .en, .val(h_r),  .root(rt_h));
  hvd_isqrt u_sqc (.clk, .en, .val(hc_r), .root(rt_c));

  // vectoring CORDIC for the angle of (sqrt(1-h), sqrt(h))
  localparam int N = hvd_pkg::CordicStages;
  hvd_pkg::q30_t vx_r [N+1];
  hvd_pkg::q30_t vy_r [N+1];
  hvd_pkg::q30_t vz_r [N+1];
  always_ff @(posedge clk) begin
    if (en) begin
      vx_r[0] <= hvd_pkg::q30_t'(rt_c);
      vy_r[0] <= hvd_pkg::q30_t'(rt_h);
      vz_r[0] <= '0;
    end
  end
  for (genvar i = 0; i < N; i++) begin : g_vec
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vy_r[i][hvd_pkg::CW-1]) begin
          vx_r[i+1] <= vx_r[i] + (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] - (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] + hvd_pkg::atan_tab(i);
        end else begin
          vx_r[i+1] <= vx_r[i] - (vy_r[i] >>> i);
          vy_r[i+1] <= vy_r[i] + (vx_r[i] >>> i);
          vz_r[i+1] <= vz_r[i] - hvd_pkg::atan_tab(i);
        end
      end
    end
  end

  // scale by radius, round, saturate
  logic [33:0] ang_r;
  logic [58:0] prod_r;
  logic [58:0] dsum;
  always_ff @(posedge clk) begin
    if (en) begin
      ang_r  <= vz_r[N][hvd_pkg::CW-1] ? '0 : {vz_r[N][32:0], 1'b0};
      prod_r <= 59'(ang_r) * 59'(radius_r);
    end
  end
  assign dsum = prod_r + (59'd1 << 29);

  logic unused;
  assign unused = ^{c1, c2, sa, sb, vx_r[N], vy_r[N], in_tdata[119:114]};

  // valid bits travel with the data; last bit fills the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[LAT-2:0], in_tvalid};
      ovld_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= (dsum[58:30] > 29'd67108863) ? 26'h3ffffff : dsum[55:30];
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {6'd0, dist_r};

endmodule
